### sv/fpa_pkg.sv
// Shared constants and types of the Fenwick tree point-add / range-sum core.
package fpa_pkg;

   localparam int SIZE_DEF = 1024;
   localparam int SIZE_REG_W = 11;
   localparam int POS_W = 11;
   localparam int DATA_W = 64;
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ADD_RD = 6'b000100,
      ST_ADD_WR = 6'b001000,
      ST_QRY    = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

endpackage

### sv/fpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module fpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/fpa_engine.sv
// Sequencer and datapath that walk the node store for adds and prefix sums.
module fpa_engine
   import fpa_pkg::*;
#(
   parameter int SIZE = SIZE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       func,
   input  logic [POS_W-1:0]           position,
   input  logic [POS_W-1:0]           left_end,
   input  logic [DATA_W-1:0]          value,
   input  logic [$clog2(SIZE+1)-1:0]  n,
   output logic                       busy,
   output logic                       rsp_strobe,
   output logic [DATA_W-1:0]          rsp_sum
);

   localparam int NW = $clog2(SIZE + 1);
   localparam int WW = ((NW > POS_W) ? NW : POS_W) + 1;

   state_type         state_ff, state_in;
   logic [WW-1:0]     x_ff, x_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [POS_W-1:0]  left_ff, left_in;
   logic              phase_ff, phase_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_neg_ff, rd_neg_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic              rd_en;
   logic [NW-1:0]     rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              wr_en;
   logic [NW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   logic [WW-1:0]     nx;
   logic [WW-1:0]     pos_w;
   logic [WW-1:0]     k_right;
   logic [WW-1:0]     left_m1;
   logic [WW-1:0]     k_left;
   logic [WW-1:0]     low_bit;
   logic [DATA_W-1:0] contrib;
   logic [DATA_W-1:0] acc_q;
   logic [DATA_W-1:0] node_new;

   fpa_ram #(
      .WIDTH(DATA_W),
      .DEPTH(SIZE + 1)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign nx = WW'(n);
   assign pos_w = WW'(position);
   assign k_right = (pos_w > nx) ? nx : pos_w;
   assign left_m1 = WW'(left_ff) - WW'(1);
   assign k_left = (left_m1 > nx) ? nx : left_m1;
   assign low_bit = x_ff & (~x_ff + WW'(1));
   assign contrib = rd_pend_ff ? (rd_neg_ff ? (~rd_data + DATA_W'(1)) : rd_data)
                               : '0;
   assign acc_q = acc_ff + contrib;
   assign node_new = rd_data + val_ff;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      val_in = val_ff;
      left_in = left_ff;
      phase_in = phase_ff;
      rd_pend_in = 1'b0;
      rd_neg_in = rd_neg_ff;
      clr_in = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_sum_in = rsp_sum_ff;
      rd_en = 1'b0;
      rd_addr = x_ff[NW-1:0];
      wr_en = 1'b0;
      wr_addr = x_ff[NW-1:0];
      wr_data = node_new;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(SIZE)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               acc_in = '0;
               if (func == FUNC_ADD) begin
                  x_in = pos_w;
                  val_in = value;
                  state_in = (position == '0) ? ST_FIN : ST_ADD_RD;
               end else begin
                  x_in = k_right;
                  left_in = left_end;
                  phase_in = 1'b0;
                  state_in = ST_QRY;
               end
            end
         end
         ST_ADD_RD: begin
            if (x_ff > nx) begin
               state_in = ST_FIN;
            end else begin
               rd_en = 1'b1;
               state_in = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            wr_en = 1'b1;
            acc_in = acc_ff + node_new;
            x_in = x_ff + low_bit;
            state_in = ST_ADD_RD;
         end
         ST_QRY: begin
            acc_in = acc_q;
            if (x_ff != '0) begin
               rd_en = 1'b1;
               rd_pend_in = 1'b1;
               rd_neg_in = phase_ff;
               x_in = x_ff - low_bit;
            end else if (!phase_ff && left_ff != '0) begin
               x_in = k_left;
               phase_in = 1'b1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_sum_in = acc_q;
            rsp_strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rd_pend_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rd_pend_ff <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      acc_ff <= acc_in;
      val_ff <= val_in;
      left_ff <= left_in;
      phase_ff <= phase_in;
      rd_neg_ff <= rd_neg_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_sum = rsp_sum_ff;

endmodule

### sv/fenwick_point_add_range_sum_core.sv
// Top level of the Fenwick tree point-add / range-sum core with its size register.
//
// The core holds SIZE+1 node sums in one synchronous RAM. After reset it clears all
// SIZE+1 words of the RAM with busy high. A word is taken when start is high and busy
// is low; its result appears on rsp_sum with rsp_strobe high for one cycle, and the
// receiver cannot stall it. A query walks up to two prefixes, the second only when
// left_end is nonzero, each of at most log2(SIZE)+1 nodes, one RAM read per cycle.
// An add does a read-modify-write of each updated node through the single RAM port
// pair, and skips the walk at position zero. The result is shown in the first cycle
// with busy low, and the next word can be taken at the end of that same cycle. The
// user must write the size register with csr_we only while busy is low; the block
// itself does not enforce it.
module fenwick_point_add_range_sum_core
   import fpa_pkg::*;
#(
   parameter int SIZE = SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_func,
   input  logic [POS_W-1:0]         req_position,
   input  logic [POS_W-1:0]         req_left_end,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_sum,
   input  logic                     csr_we,
   input  logic [SIZE_REG_W-1:0]    csr_wdata
);

   localparam int NW = $clog2(SIZE + 1);
   localparam int CW = (NW > SIZE_REG_W) ? NW : SIZE_REG_W;

   logic [SIZE_REG_W-1:0] size_ff, size_in;
   logic [CW-1:0]         size_w;
   logic [NW-1:0]         n_eff;
   logic [DATA_W-1:0]     sum_bits;

   assign size_in = csr_we ? csr_wdata : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign size_w = CW'(size_ff);
   assign n_eff = (size_w > CW'(SIZE)) ? NW'(SIZE) : NW'(size_w);

   fpa_engine #(
      .SIZE(SIZE)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_func),
      .position  (req_position),
      .left_end  (req_left_end),
      .value     (req_value),
      .n         (n_eff),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_sum   (sum_bits)
   );

   assign rsp_sum = $signed(sum_bits);

endmodule

### sv/fpa_checker.sv
// Port-level checker for the Fenwick tree core and its bind to the top level.
module fpa_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while the core is busy.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted word did not make the core busy.");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result shown without preceding work.");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("Core not busy with the clearing pass after reset.");

endmodule

bind fenwick_point_add_range_sum_core fpa_checker u_fpa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe)
);

### test/tb.sv
// Testbench for the Fenwick tree point-add / range-sum core, checked against a built-in model.
`timescale 1ns / 1ps

module tb;
   import fpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_func;
   logic [POS_W-1:0]         req_position;
   logic [POS_W-1:0]         req_left_end;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_sum;
   logic                     csr_we;
   logic [SIZE_REG_W-1:0]    csr_wdata;

   logic signed [DATA_W-1:0] tree_nodes [0:SIZE_DEF];
   logic [SIZE_REG_W-1:0]    size_model;
   logic signed [DATA_W-1:0] expected_sums [$];
   logic signed [DATA_W-1:0] got_sum;
   logic signed [DATA_W-1:0] want_sum;
   bit                       idle_enabled;
   int                       idle_cycles;
   int                       error_count;
   int                       add_count;
   int                       query_count;
   int                       sums_checked;
   int                       size_writes;

   fenwick_point_add_range_sum_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_position (req_position),
      .req_left_end (req_left_end),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_sum      (rsp_sum),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int covered_positions();
      return (int'(size_model) < SIZE_DEF) ? int'(size_model) : SIZE_DEF;
   endfunction

   function automatic logic signed [DATA_W-1:0] prefix_total(int k);
      logic signed [DATA_W-1:0] acc;
      int                       n;
      acc = '0;
      n = covered_positions();
      if (k > n) begin
         k = n;
      end
      while (k > 0) begin
         acc += tree_nodes[k];
         k -= k & -k;
      end
      return acc;
   endfunction

   function automatic logic signed [DATA_W-1:0] fenwick_predict(logic f, logic [POS_W-1:0] p,
         logic [POS_W-1:0] l, logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] acc;
      int                       x;
      int                       n;
      acc = '0;
      n = covered_positions();
      if (f == FUNC_ADD) begin
         if (p != 0) begin
            x = int'(p);
            while (x <= n) begin
               tree_nodes[x] += v;
               acc += tree_nodes[x];
               x += x & -x;
            end
         end
      end else begin
         acc = prefix_total(int'(p));
         if (l != 0) begin
            acc -= prefix_total(int'(l) - 1);
         end
      end
      return acc;
   endfunction

   task automatic send_word(input logic f, input logic [POS_W-1:0] p, input logic [POS_W-1:0] l,
         input logic signed [DATA_W-1:0] v);
      int gap;
      if (idle_enabled && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_func = f;
      req_position = p;
      req_left_end = l;
      req_value = v;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_sums = {expected_sums, fenwick_predict(f, p, l, v)};
      if (f == FUNC_ADD) begin
         add_count++;
      end else begin
         query_count++;
      end
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_size(input logic [SIZE_REG_W-1:0] new_size);
      while (expected_sums.size() != 0) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = new_size;
      @(negedge clock);
      csr_we = 1'b0;
      csr_wdata = SIZE_REG_W'($urandom_range(0, 2047));
      size_model = new_size;
      size_writes++;
   endtask

   task automatic test_field_extremes();
      send_word(FUNC_ADD, 11'd1, 11'd0, 64'sd5);
      send_word(FUNC_ADD, 11'd1024, 11'd2047, 64'sh7FFF_FFFF_FFFF_FFFF);
      send_word(FUNC_ADD, 11'd512, 11'd0, 64'sh8000_0000_0000_0000);
      send_word(FUNC_ADD, 11'd3, 11'd5, -64'sd1);
      send_word(FUNC_ADD, 11'd0, 11'd0, 64'sd77);
      send_word(FUNC_ADD, 11'd2047, 11'd0, 64'sd1);
      send_word(FUNC_ADD, 11'd1025, 11'd2047, 64'sd9);
      send_word(FUNC_QUERY, 11'd0, 11'd0, 64'sd0);
      send_word(FUNC_QUERY, 11'd1024, 11'd0, 64'sd0);
      send_word(FUNC_QUERY, 11'd2047, 11'd2047, 64'sd0);
      send_word(FUNC_QUERY, 11'd1, 11'd1, 64'sd0);
      send_word(FUNC_QUERY, 11'd4, 11'd600, 64'sd0);
      send_word(FUNC_QUERY, 11'd2047, 11'd1025, 64'sd0);
      send_word(FUNC_QUERY, 11'd1023, 11'd3, -64'sd1);
   endtask

   task automatic test_size_register();
      write_size(11'd0);
      send_word(FUNC_ADD, 11'd5, 11'd0, 64'sd3);
      send_word(FUNC_QUERY, 11'd1024, 11'd0, 64'sd0);
      write_size(11'd2047);
      send_word(FUNC_QUERY, 11'd2047, 11'd0, 64'sd0);
      send_word(FUNC_ADD, 11'd1024, 11'd0, 64'sd2);
      write_size(11'd1);
      send_word(FUNC_ADD, 11'd1, 11'd0, 64'sd10);
      send_word(FUNC_ADD, 11'd2, 11'd0, 64'sd4);
      send_word(FUNC_QUERY, 11'd1, 11'd0, 64'sd0);
      send_word(FUNC_QUERY, 11'd2047, 11'd1, 64'sd0);
      write_size(11'd1024);
      send_word(FUNC_QUERY, 11'd1024, 11'd1, 64'sd0);
   endtask

   task automatic test_random_mix(input int count, input bit idling);
      logic                     f;
      logic [POS_W-1:0]         p;
      logic [POS_W-1:0]         l;
      logic signed [DATA_W-1:0] v;
      int                       n;
      int                       top;
      idle_enabled = idling;
      n = covered_positions();
      top = (n > 0) ? n : 1;
      for (int i = 0; i < count; i++) begin
         f = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0:       p = '0;
            1:       p = POS_W'($urandom_range(0, 2047));
            2:       p = POS_W'(n);
            3:       p = POS_W'(top + 1);
            default: p = POS_W'($urandom_range(1, top));
         endcase
         case ($urandom_range(0, 7))
            0:       l = POS_W'($urandom_range(0, 2047));
            1:       l = '0;
            default: l = POS_W'($urandom_range(0, int'(p)));
         endcase
         case ($urandom_range(0, 7))
            0:       v = {$urandom, $urandom};
            1:       v = 64'sh7FFF_FFFF_FFFF_FFFF;
            2:       v = 64'sh8000_0000_0000_0000;
            3:       v = {$urandom, $urandom} >>> $urandom_range(0, 63);
            default: v = $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
         endcase
         send_word(f, p, l, v);
      end
   endtask

   task automatic test_random_sizes();
      logic [SIZE_REG_W-1:0] sizes [10];
      sizes = '{11'd1024, 11'd1, 11'd2, 11'd5, 11'd16, 11'd2047, 11'd0, 11'd100, 11'd1023,
                11'd1024};
      sizes[7] = SIZE_REG_W'($urandom_range(1, 1024));
      for (int s = 0; s < 10; s++) begin
         write_size(sizes[s]);
         for (int c = 0; c < 4; c++) begin
            test_random_mix(35, $urandom_range(0, 3) != 0);
         end
      end
   endtask

   task automatic test_back_to_back();
      write_size(SIZE_REG_W'($urandom_range(1, 1024)));
      test_random_mix(100, 1'b0);
      write_size(11'd1024);
      test_random_mix(100, 1'b0);
   endtask

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("[fenwick_point_add_range_sum_core] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_sum = rsp_sum;
         if (expected_sums.size() == 0) begin
            $display("%0t: unexpected sum word, expected none, actual %0d", $time, got_sum);
            error_count++;
         end else begin
            want_sum = expected_sums.pop_front();
            sums_checked++;
            if (got_sum !== want_sum) begin
               $display("%0t: sum mismatch, expected %0d, actual %0d", $time, want_sum, got_sum);
               error_count++;
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_ADD;
      req_position = '0;
      req_left_end = '0;
      req_value = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idle_enabled = 1'b1;
      add_count = 0;
      query_count = 0;
      size_writes = 0;
      size_model = SIZE_RESET;
      for (int i = 0; i <= SIZE_DEF; i++) begin
         tree_nodes[i] = '0;
      end
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);

      test_field_extremes();
      test_size_register();
      test_random_sizes();
      test_back_to_back();

      while (expected_sums.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d adds and %0d range queries under %0d size settings.",
               add_count, query_count, size_writes);
      $display("Checked %0d sum words, %0d mismatches.", sums_checked, error_count);
      if (error_count == 0) begin
         $display("[fenwick_point_add_range_sum_core] OK");
      end else begin
         $display("[fenwick_point_add_range_sum_core] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
sv/fpa_pkg.sv
sv/fpa_ram.sv
sv/fpa_engine.sv
sv/fenwick_point_add_range_sum_core.sv
sv/fpa_checker.sv
test/tb.sv
